/* hdl/sfd_pkg.sv */
package sfd_pkg;

    localparam int FRAME_BYTES = 12;
    localparam int CELL_COUNT  = FRAME_BYTES - 1;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int RUN_W       = $clog2(FRAME_BYTES + 1);

    localparam logic [7:0]       SYNC_BYTE = 8'hFF;
    localparam logic [7:0]       PAD_MASK  = 8'hFE;
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
    localparam logic [RUN_W-1:0] RUN_DONE  = RUN_W'(FRAME_BYTES);

    localparam int OUT_DATA_W = 104;
    localparam int OUT_USER_W = 2;

    typedef struct packed {
        logic shift;
        logic last;
    } ctrl_t;

endpackage

/* hdl/sfd_cell.sv */
module sfd_cell (
    input  logic       aclk,
    input  logic       shift,
    input  logic [7:0] byte_in,
    output logic [7:0] byte_out,
    output logic       ff_out
);
    import sfd_pkg::*;

    logic [7:0] byte_reg;
    logic       ff_reg;

    always_ff @(posedge aclk) begin
        if (shift) begin
            byte_reg <= byte_in;
            ff_reg   <= (byte_in == SYNC_BYTE);
        end
    end

    assign byte_out = byte_reg;
    assign ff_out   = ff_reg;

endmodule

/* hdl/sfd_ctrl.sv */
module sfd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic [7:0]     byte_in,
    input  logic           frame_ok,
    output sfd_pkg::ctrl_t ctrl
);
    import sfd_pkg::*;

    logic             hunting_reg, hunting_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [RUN_W-1:0] run_inc;

    assign run_inc    = (byte_in == SYNC_BYTE) ? run_reg + RUN_W'(1) : '0;
    assign ctrl.shift = accept && !hunting_reg;
    assign ctrl.last  = ctrl.shift && (pos_reg == LAST_POS);

    always_comb begin
        hunting_next = hunting_reg;
        run_next     = run_reg;
        pos_next     = pos_reg;
        if (accept) begin
            if (hunting_reg) begin
                if (run_inc == RUN_DONE) begin
                    hunting_next = 1'b0;
                    run_next     = '0;
                    pos_next     = '0;
                end else begin
                    run_next = run_inc;
                end
            end else if (pos_reg == LAST_POS) begin
                pos_next = '0;
                // A frame that fails its padding check drops us back to hunting.
                if (!frame_ok) begin
                    hunting_next = 1'b1;
                    run_next     = '0;
                end
            end else begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hunting_reg <= 1'b1;
            run_reg     <= '0;
            pos_reg     <= '0;
        end else begin
            hunting_reg <= hunting_next;
            run_reg     <= run_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

/* hdl/sensor_frame_deframer_core.sv */
// Channel  Direction  Ports                          Beat contents
// s_       in         s_tvalid/tready/tdata          one received serial byte
// m_       out        m_tvalid/tready/tdata/tuser    one decoded frame
//
// One byte is taken per cycle, back to back; the eleven-cell shift chain
// holds the earlier bytes of the frame and the twelfth completes it.
// A frame result is registered into the output register as its last byte is accepted.
// Input stalls only while a result is held and m_tready is low.
// Reset (aresetn low, synchronous) starts the sync hunt and empties the output.
module sensor_frame_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] sensor_id, [2] chan_found, [6:3] chan_num, [7] slow_bit,
    // [23:8] pulse_width, [49:24] sweep_offset, [73:50] beam_word,
    // [97:74] time_stamp, [103:98] zero
    output logic [sfd_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [sfd_pkg::OUT_USER_W-1:0] m_tuser   // [0] is_sync, [1] frame_ok
);
    import sfd_pkg::*;

    ctrl_t      ctrl;
    logic       accept;
    logic [7:0] cell_q  [CELL_COUNT];
    logic       cell_ff [CELL_COUNT];
    logic [7:0] fb      [FRAME_BYTES];
    logic [FRAME_BYTES-1:0] ff_vec;
    logic       is_sync, frame_ok;

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_USER_W-1:0] m_user_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    sfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .byte_in  (s_tdata),
        .frame_ok (frame_ok),
        .ctrl     (ctrl)
    );

    // Bytes enter at the top cell and walk down; cell k holds frame byte k
    // when the last byte of the frame arrives.
    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        logic [7:0] din;
        if (k == CELL_COUNT - 1) begin : g_top
            assign din = s_tdata;
        end else begin : g_mid
            assign din = cell_q[k+1];
        end
        sfd_cell u_cell (
            .aclk     (aclk),
            .shift    (ctrl.shift),
            .byte_in  (din),
            .byte_out (cell_q[k]),
            .ff_out   (cell_ff[k])
        );
        assign fb[k]     = cell_q[k];
        assign ff_vec[k] = cell_ff[k];
    end

    assign fb[FRAME_BYTES-1]     = s_tdata;
    assign ff_vec[FRAME_BYTES-1] = (s_tdata == SYNC_BYTE);

    assign is_sync  = &ff_vec;
    assign frame_ok = (((fb[5] | fb[8]) & PAD_MASK) == 8'h00) || is_sync;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.last) begin
            m_user_reg <= {frame_ok, is_sync};
            m_data_reg <= {6'b0,
                           fb[11], fb[10], fb[9],
                           fb[8], fb[7], fb[6],
                           fb[5], fb[4], fb[3], 2'b00,
                           fb[2], fb[1],
                           fb[0][2], fb[0][6:3], ~fb[0][7], fb[0][1:0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
